// File: rtl/pcqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcqp_pkg
// Types, field widths and helpers shared by the pointwise convolution block.
// ----------------------------------------------------------------------------
package pcqp_pkg;

  localparam int unsigned CH_W   = 5;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned ACC_W  = 40;

  localparam int IN_CHANNELS_DEF  = 24;
  localparam int OUT_CHANNELS_DEF = 24;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_ACT  = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e                  opcode;
    logic [CH_W-1:0]          in_channel;
    logic [CH_W-1:0]          out_channel;
    logic signed [DATA_W-1:0] data_value;
    logic                     end_of_pixel;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel_out;
    logic signed [ACC_W-1:0] partial_sum_q0;
    logic signed [ACC_W-1:0] partial_sum_q1;
    logic signed [ACC_W-1:0] partial_sum_q2;
    logic signed [ACC_W-1:0] partial_sum_q3;
    logic                    last_of_pixel;
  } out_item_t;

  // One accumulator row: the four quarter sums of one output channel
  typedef logic [3:0][ACC_W-1:0] acc_row_t;
  typedef logic [1:0] quarter_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_EMIT_RD,
    ST_EMIT_LD
  } seq_state_e;

  typedef struct packed {
    logic w_wr;      // weight write from the input item
    logic w_rd;      // weight read, one MAC issued
    logic acc_rd;    // accumulator row read
    logic acc_clr;   // drop all accumulator rows
    logic out_load;  // load the output register
    logic out_last;  // final output channel of the pixel
  } seq_ctrl_t;

  // Index width for a store of n entries, at least one bit
  function automatic int unsigned idx_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// File: rtl/pcqp_wmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcqp_wmem
// Weight store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcqp_wmem import pcqp_pkg::*; #(
  parameter int IN_CHANNELS  = IN_CHANNELS_DEF,
  parameter int OUT_CHANNELS = OUT_CHANNELS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          wr_en_i,
  input  logic                                          rd_en_i,
  input  logic [idx_w(IN_CHANNELS*OUT_CHANNELS)-1:0]    addr_i,
  input  logic signed [DATA_W-1:0]                      wr_data_i,
  output logic signed [DATA_W-1:0]                      rd_data_o
);

  logic signed [DATA_W-1:0] mem_q [IN_CHANNELS*OUT_CHANNELS];
  logic signed [DATA_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: rtl/pcqp_amem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcqp_amem
// Accumulator rows, one per output channel, with a valid bit per row.
// A row that is not valid reads as zero.
// ----------------------------------------------------------------------------
module pcqp_amem import pcqp_pkg::*; #(
  parameter int OUT_CHANNELS = OUT_CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [idx_w(OUT_CHANNELS)-1:0] rd_row_i,
  input  logic                           clr_i,
  input  logic                           wr_en_i,
  input  logic [idx_w(OUT_CHANNELS)-1:0] wr_row_i,
  input  acc_row_t                       wr_data_i,
  output acc_row_t                       rd_data_o
);

  acc_row_t                mem_q [OUT_CHANNELS];
  logic [OUT_CHANNELS-1:0] vld_q;
  acc_row_t                rd_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_row_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_row_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_row_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: rtl/pcqp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcqp_mac
// Shared multiply-accumulate: product register, then add into the selected
// quarter of the row and write the row back.
// ----------------------------------------------------------------------------
module pcqp_mac import pcqp_pkg::*; #(
  parameter int OUT_CHANNELS = OUT_CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  seq_ctrl_t                      ctrl_i,
  input  logic [idx_w(OUT_CHANNELS)-1:0] row_i,
  input  logic signed [DATA_W-1:0]       act_i,
  input  quarter_t                       quarter_i,
  input  logic signed [DATA_W-1:0]       w_data_i,
  input  acc_row_t                       acc_row_i,
  output logic                           wr_en_o,
  output logic [idx_w(OUT_CHANNELS)-1:0] wr_row_o,
  output acc_row_t                       wr_data_o
);

  localparam int unsigned OC_W = idx_w(OUT_CHANNELS);

  logic                       s1_v_q, s2_v_q;
  logic [OC_W-1:0]            s1_row_q, s2_row_q;
  logic signed [2*DATA_W-1:0] prod_q;
  acc_row_t                   s2_acc_q;
  logic [ACC_W-1:0]           sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= ctrl_i.w_rd;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q <= row_i;
    s2_row_q <= s1_row_q;
    prod_q   <= act_i * w_data_i;
    s2_acc_q <= acc_row_i;
  end

  // Sign-extend the product into the accumulator width; the add wraps
  assign sum = s2_acc_q[quarter_i] + ACC_W'(prod_q);

  always_comb begin
    wr_data_o            = s2_acc_q;
    wr_data_o[quarter_i] = sum;
  end

  assign wr_en_o  = s2_v_q;
  assign wr_row_o = s2_row_q;

endmodule

// File: rtl/pcqp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcqp_seq
// Sequencer: takes items, sweeps the output channels through the shared MAC
// and steps the results out one row at a time.
// ----------------------------------------------------------------------------
module pcqp_seq import pcqp_pkg::*; #(
  parameter int IN_CHANNELS  = IN_CHANNELS_DEF,
  parameter int OUT_CHANNELS = OUT_CHANNELS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  in_item_t                                   in_item_i,
  input  logic                                       out_free_i,
  output seq_ctrl_t                                  ctrl_o,
  output logic [idx_w(IN_CHANNELS*OUT_CHANNELS)-1:0] w_addr_o,
  output logic [idx_w(OUT_CHANNELS)-1:0]             row_o,
  output logic signed [DATA_W-1:0]                   act_o,
  output quarter_t                                   quarter_o
);

  localparam int unsigned OC_W = idx_w(OUT_CHANNELS);
  localparam int unsigned WA_W = idx_w(IN_CHANNELS * OUT_CHANNELS);
  localparam int Q1 = IN_CHANNELS / 4;
  localparam int Q2 = IN_CHANNELS / 2;
  localparam int Q3 = 3 * IN_CHANNELS / 4;

  seq_state_e               state_q, state_d;
  logic [OC_W-1:0]          cnt_q, cnt_d;
  logic [WA_W-1:0]          waddr_q, waddr_d;
  logic signed [DATA_W-1:0] act_q, act_d;
  quarter_t                 quar_q, quar_d;
  logic                     eop_q, eop_d;

  logic [CH_W-1:0] ic, oc;
  logic            ic_ok, oc_ok, last_cnt;
  quarter_t        quar_in;
  logic [WA_W-1:0] load_addr;

  assign ic       = in_item_i.in_channel;
  assign oc       = in_item_i.out_channel;
  assign ic_ok    = int'(ic) < IN_CHANNELS;
  assign oc_ok    = int'(oc) < OUT_CHANNELS;
  assign last_cnt = (cnt_q == OC_W'(OUT_CHANNELS - 1));
  assign quar_in  = (int'(ic) >= Q3) ? 2'd3 :
                    (int'(ic) >= Q2) ? 2'd2 :
                    (int'(ic) >= Q1) ? 2'd1 : 2'd0;
  assign load_addr = WA_W'(int'(oc) * IN_CHANNELS + int'(ic));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_q <= waddr_d;
    act_q   <= act_d;
    quar_q  <= quar_d;
    eop_q   <= eop_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    waddr_d = waddr_q;
    act_d   = act_q;
    quar_d  = quar_q;
    eop_d   = eop_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.opcode == OP_LOAD) begin
            ctrl_o.w_wr = ic_ok && oc_ok;
          end else begin
            act_d   = in_item_i.data_value;
            quar_d  = quar_in;
            eop_d   = in_item_i.end_of_pixel;
            cnt_d   = '0;
            waddr_d = WA_W'(ic);
            // an activation outside the channel range adds nothing
            if (ic_ok) begin
              state_d = ST_ACCUM;
            end else if (in_item_i.end_of_pixel) begin
              state_d = ST_EMIT_RD;
            end
          end
        end
      end
      ST_ACCUM: begin
        ctrl_o.w_rd   = 1'b1;
        ctrl_o.acc_rd = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        waddr_d       = waddr_q + WA_W'(IN_CHANNELS);
        if (last_cnt) begin
          cnt_d   = '0;
          state_d = ST_DRAIN1;
        end
      end
      // let the last row writes land before anything reads the rows again
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = eop_q ? ST_EMIT_RD : ST_IDLE;
      ST_EMIT_RD: begin
        ctrl_o.acc_rd = 1'b1;
        state_d       = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_last = last_cnt;
          cnt_d           = cnt_q + 1'b1;
          state_d         = ST_EMIT_RD;
          if (last_cnt) begin
            ctrl_o.acc_clr = 1'b1;
            cnt_d          = '0;
            state_d        = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign w_addr_o   = (state_q == ST_IDLE) ? load_addr : waddr_q;
  assign row_o      = cnt_q;
  assign act_o      = act_q;
  assign quarter_o  = quar_q;

endmodule

// File: rtl/pointwise_conv_quarter_partials.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointwise_conv_quarter_partials
// 1x1 convolution engine with four quarter partial sums per output channel.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o / in_item_i. A weight-load item
// writes one entry of the weight store when both its channels are in range.
// An in-range activation item runs one multiply-accumulate per output
// channel through a single shared MAC: the sweep over the output channels,
// then the two-stage MAC pipeline draining.
// An activation marked end of pixel then emits OUT_CHANNELS items on
// out_valid_o / out_stall_i / out_item_o, in ascending channel order, each
// item a row read, then an output register load; last_of_pixel marks the
// final one, and the accumulators are cleared with it. in_stall_o stays
// high until the item's work is done.
// A stalled output item holds in the output register and the emission waits.
// Reset clears the accumulators and all control state at once; the weight
// store has no reset and must be loaded before use. Channel counts up to 32.
// ----------------------------------------------------------------------------
module pointwise_conv_quarter_partials import pcqp_pkg::*; #(
  parameter int IN_CHANNELS  = IN_CHANNELS_DEF,
  parameter int OUT_CHANNELS = OUT_CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned OC_W = idx_w(OUT_CHANNELS);
  localparam int unsigned WA_W = idx_w(IN_CHANNELS * OUT_CHANNELS);

  seq_ctrl_t                ctrl;
  logic [WA_W-1:0]          w_addr;
  logic [OC_W-1:0]          row;
  logic signed [DATA_W-1:0] act;
  quarter_t                 quarter;
  logic signed [DATA_W-1:0] w_data;
  acc_row_t                 acc_rd;
  logic                     acc_wr_en;
  logic [OC_W-1:0]          acc_wr_row;
  acc_row_t                 acc_wr_data;
  logic                     out_free;
  logic                     out_vld_q;
  out_item_t                out_q;

  pcqp_seq #(
    .IN_CHANNELS  (IN_CHANNELS),
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .w_addr_o   (w_addr),
    .row_o      (row),
    .act_o      (act),
    .quarter_o  (quarter)
  );

  pcqp_wmem #(
    .IN_CHANNELS  (IN_CHANNELS),
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_wmem (
    .clk_i     (clk_i),
    .wr_en_i   (ctrl.w_wr),
    .rd_en_i   (ctrl.w_rd),
    .addr_i    (w_addr),
    .wr_data_i (in_item_i.data_value),
    .rd_data_o (w_data)
  );

  pcqp_amem #(
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_amem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ctrl.acc_rd),
    .rd_row_i  (row),
    .clr_i     (ctrl.acc_clr),
    .wr_en_i   (acc_wr_en),
    .wr_row_i  (acc_wr_row),
    .wr_data_i (acc_wr_data),
    .rd_data_o (acc_rd)
  );

  pcqp_mac #(
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .row_i     (row),
    .act_i     (act),
    .quarter_i (quarter),
    .w_data_i  (w_data),
    .acc_row_i (acc_rd),
    .wr_en_o   (acc_wr_en),
    .wr_row_o  (acc_wr_row),
    .wr_data_o (acc_wr_data)
  );

  // Output register: free when empty or being taken this cycle
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_q.channel_out    <= CH_W'(row);
      out_q.partial_sum_q0 <= acc_rd[0];
      out_q.partial_sum_q1 <= acc_rd[1];
      out_q.partial_sum_q2 <= acc_rd[2];
      out_q.partial_sum_q3 <= acc_rd[3];
      out_q.last_of_pixel  <= ctrl.out_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
